// ----- rtl/core/bbsf_pkg.sv -----
package bbsf_pkg;

    // Fixed field widths
    localparam int CNT_W = 13;
    localparam int LEN_W = 7;
    localparam int TOT_W = 32;
    localparam int KIND_W = 3;
    localparam int BYTE_W = 8;

    // Reset value of the capacity register
    localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 3'd0,
        KIND_READ  = 3'd1,
        KIND_PEEK  = 3'd2,
        KIND_POP   = 3'd3,
        KIND_END   = 3'd4
    } kind_t;

    // FIFO status after the last applied request
    typedef struct packed {
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] eff_cap;
        logic [TOT_W-1:0] in_total;
        logic [TOT_W-1:0] out_total;
        logic             ended;
    } stat_t;

    // Per-result flags, registered
    typedef struct packed {
        logic strobe;
        logic valid;
        logic last;
        logic accepted;
    } res_t;

endpackage

// ----- rtl/core/bbsf_ram.sv -----
module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/bbsf_ctrl.sv -----
module bbsf_ctrl
    import bbsf_pkg::*;
#(
    parameter int DEPTH   = 4096,
    parameter int MAX_RUN = 64,
    parameter int AW      = (DEPTH > 1 ? $clog2(DEPTH) : 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KIND_W-1:0] kind,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [LEN_W-1:0]  length,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_data,
    output logic              busy,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [BYTE_W-1:0] ram_wdata,
    output logic              ram_re,
    output logic [AW-1:0]     ram_raddr,
    output stat_t             stat,
    output res_t              res
);

    localparam bit               DEPTH_BIG = DEPTH > 8191;
    localparam logic [CNT_W-1:0] DEPTH_CNT = DEPTH_BIG ? '1 : CNT_W'(DEPTH);

    logic [CNT_W-1:0] capacity_reg;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [TOT_W-1:0] in_total_reg, in_total_next;
    logic [TOT_W-1:0] out_total_reg, out_total_next;
    logic             ended_reg, ended_next;
    logic [AW-1:0]    run_addr_reg, run_addr_next;
    logic [LEN_W-1:0] run_left_reg, run_left_next;
    res_t             res_reg, res_next;

    logic             accept;
    logic [CNT_W-1:0] eff_cap;
    logic [LEN_W-1:0] n_avail;
    logic [LEN_W-1:0] n_run;
    logic [AW-1:0]    head_pop;
    logic [AW-1:0]    head_rd;

    // Advance an index by one around the ring
    function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // Advance an index by n around the ring, n never above DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [LEN_W-1:0] n);
        logic [AW:0] s;
        s = {1'b0, base} + (AW+1)'(n);
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign busy   = (run_left_reg != '0);
    assign accept = start && !busy;

    // Clamp capacity to the storage depth
    assign eff_cap = (DEPTH_BIG || capacity_reg < DEPTH_CNT) ? capacity_reg : DEPTH_CNT;

    // Bytes available to a read, peek or pop, and the read run length
    assign n_avail  = (CNT_W'(length) < used_reg) ? length : LEN_W'(used_reg);
    assign n_run    = (n_avail > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : n_avail;
    assign head_pop = wrap_add(head_reg, n_avail);
    assign head_rd  = wrap_add(head_reg, n_run);

    assign ram_waddr = tail_reg;
    assign ram_wdata = data_byte;

    // Apply a request or step the read run
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        used_next      = used_reg;
        in_total_next  = in_total_reg;
        out_total_next = out_total_reg;
        ended_next     = ended_reg;
        run_addr_next  = run_addr_reg;
        run_left_next  = run_left_reg;
        res_next       = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = head_reg;

        if (busy)
        begin
            ram_re          = 1'b1;
            ram_raddr       = run_addr_reg;
            run_addr_next   = inc_idx(run_addr_reg);
            run_left_next   = run_left_reg - 1'b1;
            res_next.strobe = 1'b1;
            res_next.valid  = 1'b1;
            res_next.last   = (run_left_reg == LEN_W'(1));
        end
        else if (accept)
        begin
            res_next.strobe = 1'b1;
            res_next.last   = 1'b1;
            case (kind_t'(kind))
                KIND_WRITE:
                begin
                    if (used_reg < eff_cap)
                    begin
                        ram_we            = 1'b1;
                        tail_next         = inc_idx(tail_reg);
                        used_next         = used_reg + 1'b1;
                        in_total_next     = in_total_reg + 1'b1;
                        res_next.accepted = 1'b1;
                    end
                end
                KIND_READ, KIND_PEEK:
                begin
                    if (n_run != '0)
                    begin
                        ram_re         = 1'b1;
                        run_addr_next  = inc_idx(head_reg);
                        run_left_next  = n_run - 1'b1;
                        res_next.valid = 1'b1;
                        res_next.last  = (n_run == LEN_W'(1));
                        if (kind_t'(kind) == KIND_READ)
                        begin
                            head_next      = head_rd;
                            used_next      = used_reg - CNT_W'(n_run);
                            out_total_next = out_total_reg + TOT_W'(n_run);
                        end
                    end
                end
                KIND_POP:
                begin
                    head_next      = head_pop;
                    used_next      = used_reg - CNT_W'(n_avail);
                    out_total_next = out_total_reg + TOT_W'(n_avail);
                end
                KIND_END:
                begin
                    ended_next = 1'b1;
                end
                default:
                begin
                    ended_next = ended_reg;
                end
            endcase
        end
    end

    // Hold state, capacity and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            used_reg      <= '0;
            in_total_reg  <= '0;
            out_total_reg <= '0;
            ended_reg     <= 1'b0;
            run_addr_reg  <= '0;
            run_left_reg  <= '0;
            res_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            used_reg      <= used_next;
            in_total_reg  <= in_total_next;
            out_total_reg <= out_total_next;
            ended_reg     <= ended_next;
            run_addr_reg  <= run_addr_next;
            run_left_reg  <= run_left_next;
            res_reg       <= res_next;
        end
    end

    assign stat.used      = used_reg;
    assign stat.eff_cap   = eff_cap;
    assign stat.in_total  = in_total_reg;
    assign stat.out_total = out_total_reg;
    assign stat.ended     = ended_reg;
    assign res            = res_reg;

endmodule

// ----- rtl/core/bounded_byte_stream_fifo.sv -----
// Every request gives its first result in the cycle after it is accepted.
// Read and peek of n bytes (length capped at occupancy and MAX_RUN) give n results on
// consecutive cycles, as the single read port fetches one byte a cycle; busy stays high
// until the last is fetched. One write, pop or end request per cycle when busy is low.
// Reset clears pointers, counts, totals and the end flag and sets capacity to 4096;
// the byte store is not cleared. The receiver cannot stall: results are strobed once.
module bounded_byte_stream_fifo
    import bbsf_pkg::*;
#(
    parameter int DEPTH   = 4096,
    parameter int MAX_RUN = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [KIND_W-1:0] kind,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [LEN_W-1:0]  length,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_data,
    output logic              result_valid,
    output logic [BYTE_W-1:0] byte_out,
    output logic              byte_valid,
    output logic              last,
    output logic              accepted,
    output logic [CNT_W-1:0]  occupancy,
    output logic [CNT_W-1:0]  space_left,
    output logic [TOT_W-1:0]  written_total,
    output logic [TOT_W-1:0]  read_total,
    output logic              input_done,
    output logic              at_eof
);

    localparam int AW = (DEPTH > 1 ? $clog2(DEPTH) : 1);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    stat_t             stat;
    res_t              res;

    bbsf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bbsf_ctrl #(
        .DEPTH   (DEPTH),
        .MAX_RUN (MAX_RUN),
        .AW      (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .data_byte (data_byte),
        .length    (length),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .stat      (stat),
        .res       (res)
    );

    // Drive the result from the flags and the status after the request
    assign result_valid  = res.strobe;
    assign byte_valid    = res.valid;
    assign byte_out      = res.valid ? ram_rdata : '0;
    assign last          = res.last;
    assign accepted      = res.accepted;
    assign occupancy     = stat.used;
    assign space_left    = (stat.eff_cap > stat.used) ? stat.eff_cap - stat.used : '0;
    assign written_total = stat.in_total;
    assign read_total    = stat.out_total;
    assign input_done    = stat.ended;
    assign at_eof        = stat.ended && (stat.used == '0);

endmodule

// ----- sim/bounded_byte_stream_fifo_test.sv -----
module bounded_byte_stream_fifo_test;
    import bbsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = 4096;
    localparam int MAX_RUN = 64;
    localparam logic [KIND_W-1:0] KIND_TOP = '1;
    localparam logic [LEN_W-1:0]  LEN_TOP  = '1;
    localparam logic [CNT_W-1:0]  CAP_TOP  = '1;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  length;
    } fifo_req_t;

    typedef struct {
        logic [BYTE_W-1:0] byte_val;
        logic              valid;
        logic              last;
        logic              acc;
        logic [CNT_W-1:0]  occ;
        logic [CNT_W-1:0]  space;
        logic [TOT_W-1:0]  wr_tot;
        logic [TOT_W-1:0]  rd_tot;
        logic              done;
        logic              eof;
    } fifo_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [KIND_W-1:0] kind = '0;
    logic [BYTE_W-1:0] data_byte = '0;
    logic [LEN_W-1:0]  length = '0;
    logic              cfg_we = 1'b0;
    logic [CNT_W-1:0]  cfg_data = '0;
    logic              result_valid;
    logic [BYTE_W-1:0] byte_out;
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic [CNT_W-1:0]  occupancy;
    logic [CNT_W-1:0]  space_left;
    logic [TOT_W-1:0]  written_total;
    logic [TOT_W-1:0]  read_total;
    logic              input_done;
    logic              at_eof;

    // Shadow copy of the FIFO state
    logic [BYTE_W-1:0] fifo_bytes [DEPTH];
    int unsigned       rd_ptr = 0;
    int unsigned       wr_ptr = 0;
    int unsigned       held = 0;
    logic [TOT_W-1:0]  bytes_in = '0;
    logic [TOT_W-1:0]  bytes_out = '0;
    logic              end_seen = 1'b0;
    logic [CNT_W-1:0]  capacity = CAP_RESET;

    fifo_req_t    pending_requests [$];
    fifo_result_t expected_results [$];
    fifo_req_t    cur_req;
    fifo_result_t want;
    int           mismatch_count = 0;
    int           burst_left = 0;
    int           gap_left = 0;

    bounded_byte_stream_fifo #(
        .DEPTH   (DEPTH),
        .MAX_RUN (MAX_RUN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .data_byte     (data_byte),
        .length        (length),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .byte_out      (byte_out),
        .byte_valid    (byte_valid),
        .last          (last),
        .accepted      (accepted),
        .occupancy     (occupancy),
        .space_left    (space_left),
        .written_total (written_total),
        .read_total    (read_total),
        .input_done    (input_done),
        .at_eof        (at_eof)
    );

    always #10 clk = ~clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t",
                     what, got, exp_val, $realtime);
    endtask

    // Apply one request to the shadow state and queue the results it causes
    function automatic void apply_request(input fifo_req_t r);
        int unsigned       n;
        int unsigned       idx;
        int unsigned       eff_cap;
        int unsigned       i;
        logic              took;
        logic [BYTE_W-1:0] run_bytes [$];
        fifo_result_t      res;
        took = 1'b0;
        n = 0;
        eff_cap = (capacity < DEPTH) ? capacity : DEPTH;
        if (r.kind == KIND_READ || r.kind == KIND_PEEK)
        begin
            n = (r.length < held) ? r.length : held;
            if (n > MAX_RUN)
                n = MAX_RUN;
            idx = rd_ptr;
            for (i = 0; i < n; i++)
            begin
                run_bytes.insert(run_bytes.size(), fifo_bytes[idx]);
                idx = (idx + 1) % DEPTH;
            end
            if (r.kind == KIND_READ)
            begin
                rd_ptr = idx;
                held -= n;
                bytes_out += n;
            end
        end
        else if (r.kind == KIND_WRITE)
        begin
            if (held < eff_cap)
            begin
                fifo_bytes[wr_ptr] = r.data;
                wr_ptr = (wr_ptr + 1) % DEPTH;
                held++;
                bytes_in += 1;
                took = 1'b1;
            end
        end
        else if (r.kind == KIND_POP)
        begin
            n = (r.length < held) ? r.length : held;
            rd_ptr = (rd_ptr + n) % DEPTH;
            held -= n;
            bytes_out += n;
        end
        else if (r.kind == KIND_END)
        begin
            end_seen = 1'b1;
        end

        // Status reflects the state after the whole request
        res.occ    = held[CNT_W-1:0];
        res.space  = (eff_cap > held) ? CNT_W'(eff_cap - held) : '0;
        res.wr_tot = bytes_in;
        res.rd_tot = bytes_out;
        res.done   = end_seen;
        res.eof    = end_seen && held == 0;
        res.acc    = took;
        if (run_bytes.size() == 0)
        begin
            res.byte_val = '0;
            res.valid    = 1'b0;
            res.last     = 1'b1;
            expected_results.insert(expected_results.size(), res);
        end
        else
        begin
            for (i = 0; i < run_bytes.size(); i++)
            begin
                res.byte_val = run_bytes[i];
                res.valid    = 1'b1;
                res.last     = (i + 1 == run_bytes.size());
                expected_results.insert(expected_results.size(), res);
            end
        end
    endfunction

    function automatic void queue_request(input logic [KIND_W-1:0] k,
                                          input logic [BYTE_W-1:0] d,
                                          input logic [LEN_W-1:0] l);
        fifo_req_t r;
        r.kind = k;
        r.data = d;
        r.length = l;
        pending_requests.insert(pending_requests.size(), r);
    endfunction

    function automatic void queue_write_run(input int count);
        int i;
        for (i = 0; i < count; i++)
            queue_request(KIND_WRITE, BYTE_W'($urandom_range(0, 255)),
                          LEN_W'($urandom_range(0, LEN_TOP)));
    endfunction

    // Mostly writes to keep bytes in flight, mixed with reads, peeks and pops
    function automatic void queue_random(input int count, input bit allow_end);
        int                i;
        int unsigned       pick;
        int unsigned       lsel;
        logic [KIND_W-1:0] k;
        logic [LEN_W-1:0]  l;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                k = KIND_WRITE;
            else if (pick < 65)
                k = KIND_READ;
            else if (pick < 77)
                k = KIND_PEEK;
            else if (pick < 89)
                k = KIND_POP;
            else if (pick < 95)
                k = KIND_W'($urandom_range(KIND_END + 1, KIND_TOP));
            else
                k = allow_end ? KIND_END : KIND_WRITE;
            lsel = $urandom_range(0, 99);
            if (lsel < 80)
                l = LEN_W'($urandom_range(0, 16));
            else if (lsel < 92)
                l = LEN_W'($urandom_range(17, MAX_RUN));
            else
                l = LEN_W'($urandom_range(MAX_RUN + 1, LEN_TOP));
            queue_request(k, BYTE_W'($urandom_range(0, 255)), l);
        end
    endfunction

    // Hold until every request is taken and every result has come back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || start || expected_results.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        capacity = value;
    endtask

    // Request driver: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                apply_request(cur_req);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    cur_req = pending_requests[0];
                    pending_requests.delete(0);
                    start <= 1'b1;
                    kind <= cur_req.kind;
                    data_byte <= cur_req.data;
                    length <= cur_req.length;
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                flag_mismatch("result with nothing outstanding", byte_out, 0);
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (byte_out !== want.byte_val)
                    flag_mismatch("byte_out", byte_out, want.byte_val);
                if (byte_valid !== want.valid)
                    flag_mismatch("byte_valid", byte_valid, want.valid);
                if (last !== want.last)
                    flag_mismatch("last", last, want.last);
                if (accepted !== want.acc)
                    flag_mismatch("accepted", accepted, want.acc);
                if (occupancy !== want.occ)
                    flag_mismatch("occupancy", occupancy, want.occ);
                if (space_left !== want.space)
                    flag_mismatch("space_left", space_left, want.space);
                if (written_total !== want.wr_tot)
                    flag_mismatch("written_total", written_total, want.wr_tot);
                if (read_total !== want.rd_tot)
                    flag_mismatch("read_total", read_total, want.rd_tot);
                if (input_done !== want.done)
                    flag_mismatch("input_done", input_done, want.done);
                if (at_eof !== want.eof)
                    flag_mismatch("at_eof", at_eof, want.eof);
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("bounded_byte_stream_fifo_test: FAIL");
        $finish;
    end

    initial
    begin
        int k;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Empty FIFO, zero length, byte extremes, run past occupancy, unknown kinds
        queue_request(KIND_READ, 8'h00, 7'd5);
        queue_request(KIND_PEEK, 8'hFF, 7'd0);
        queue_request(KIND_POP, 8'h00, 7'd3);
        queue_request(KIND_WRITE, 8'h00, 7'd0);
        queue_request(KIND_WRITE, 8'hFF, LEN_TOP);
        queue_request(KIND_WRITE, 8'hA5, 7'd0);
        queue_request(KIND_WRITE, 8'h5A, 7'd0);
        queue_request(KIND_PEEK, 8'h00, 7'd0);
        queue_request(KIND_PEEK, 8'h00, 7'd3);
        queue_request(KIND_READ, 8'h00, 7'd1);
        queue_request(KIND_POP, 8'h00, 7'd1);
        queue_request(KIND_READ, 8'h00, LEN_TOP);
        for (k = KIND_END + 1; k <= KIND_TOP; k++)
            queue_request(KIND_W'(k), BYTE_W'($urandom_range(0, 255)),
                          LEN_W'($urandom_range(0, LEN_TOP)));
        queue_request(KIND_WRITE, 8'hFF, 7'd0);

        // Zero capacity refuses every write
        write_capacity('0);
        queue_request(KIND_WRITE, 8'h11, 7'd0);
        queue_request(KIND_READ, 8'h00, 7'd4);
        queue_request(KIND_POP, 8'h00, 7'd0);
        queue_request(KIND_WRITE, 8'hEE, 7'd1);

        // Capacity above storage depth; runs longer than the run limit
        write_capacity(CAP_TOP);
        queue_write_run(70);
        queue_request(KIND_READ, 8'h00, LEN_TOP);
        queue_request(KIND_PEEK, 8'h00, LEN_TOP);
        queue_request(KIND_POP, 8'h00, LEN_TOP);
        queue_random(10, 1'b0);

        // Small capacities: frequent refusals
        write_capacity(13'd5);
        queue_random(10, 1'b0);
        write_capacity(13'd1);
        queue_random(8, 1'b0);

        // Capacity dropped below occupancy keeps held bytes
        write_capacity(CAP_RESET);
        queue_write_run(10);
        write_capacity(13'd4);
        queue_request(KIND_WRITE, 8'h81, 7'd0);
        queue_request(KIND_PEEK, 8'h00, 7'd2);
        queue_request(KIND_READ, 8'h00, 7'd3);
        queue_request(KIND_POP, 8'h00, 7'd2);
        queue_request(KIND_READ, 8'h00, 7'd1);
        queue_request(KIND_WRITE, 8'h7E, 7'd0);
        queue_request(KIND_READ, 8'h00, 7'd2);
        queue_request(KIND_WRITE, 8'h3C, 7'd0);

        // End of input, writes after it, drain to end of file
        write_capacity(CAP_RESET);
        queue_request(KIND_END, 8'h00, 7'd0);
        queue_request(KIND_WRITE, 8'hC3, 7'd0);
        queue_request(KIND_READ, 8'h00, MAX_RUN);
        queue_request(KIND_END, 8'h00, 7'd0);
        queue_random(12, 1'b1);
        queue_request(KIND_POP, 8'h00, LEN_TOP);
        queue_request(KIND_PEEK, 8'h00, 7'd1);

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("bounded_byte_stream_fifo_test: PASS");
        else
            $display("bounded_byte_stream_fifo_test: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bbsf_pkg.sv
rtl/core/bbsf_ram.sv
rtl/core/bbsf_ctrl.sv
rtl/core/bounded_byte_stream_fifo.sv
sim/bounded_byte_stream_fifo_test.sv
